@@ hdl/h3_hashed_access_counter_table_core_assert.svh @@
// Assertion macros shared by the counter table RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef H3_HASHED_ACCESS_COUNTER_TABLE_CORE_ASSERT_SVH
`define H3_HASHED_ACCESS_COUNTER_TABLE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define H3ACT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("h3act assertion failed");
// Condition must never be true outside reset.
`define H3ACT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("h3act forbidden condition seen");
`else
`define H3ACT_ASSERT(lbl, clk, rst_n, prop)
`define H3ACT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/h3act_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package h3act_pkg;

  localparam int unsigned KEY_W     = 16;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned HASH_ROWS = 16;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned ENTRY_W   = 1 + KEY_W + CNT_W;
  localparam int unsigned ROW_GRPS  = 4;

  localparam logic [CNT_W-1:0]   LIMIT_RESET = 16'd128;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } h3act_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_LIMIT = 3'd0,
    CFG_HASH_ROWS_A = 3'd1,
    CFG_HASH_ROWS_B = 3'd2,
    CFG_HASH_ROWS_C = 3'd3,
    CFG_HASH_ROWS_D = 3'd4
  } h3act_cfg_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } h3act_state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } h3act_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]   access_count;
    logic [TOTAL_W-1:0] total_count;
    logic               key_found;
    logic               blocked;
    logic               bucket_full;
    logic               table_empty;
  } h3act_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } h3act_entry_t;

  typedef logic [HASH_ROWS-1:0][KEY_W-1:0] h3act_rows_t;

endpackage
`default_nettype wire

@@ hdl/h3act_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none
module h3act_hash (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [h3act_pkg::KEY_W-1:0]  key_i,
  input  wire h3act_pkg::h3act_rows_t       rows_i,
  output logic                              done_o,
  output logic [h3act_pkg::KEY_W-1:0]       hash_o
);
  import h3act_pkg::*;

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(HASH_ROWS - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  acc_q;

  // Step r folds in row r when key bit (15 - r) is set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q ^ (key_q[~step_q] ? rows_i[step_q] : '0);
    end
  end

  assign done_o = done_q;
  assign hash_o = acc_q;

endmodule
`default_nettype wire

@@ hdl/h3act_bucket_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module h3act_bucket_ram #(
  parameter int unsigned AddrW = 16,
  parameter int unsigned DataW = 132
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);
  localparam int unsigned Depth = 1 << AddrW;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hdl/h3_hashed_access_counter_table_core.sv @@
// After acceptance a request runs the shared H3 XOR step over each hash row,
// launches the bucket read, compares the WAYS ways in turn, does one update and
// loads the output register, which returns its response.
// One insert, query or remove is in flight at a time.
// Clear and reset walk every bucket, one per cycle, and take no requests meanwhile.
// Reset: count limit 128, hash rows 0, total 0, output empty, then the clearing walk.
`timescale 1ns / 1ps
`default_nettype none
`include "h3_hashed_access_counter_table_core_assert.svh"
module h3_hashed_access_counter_table_core #(
  parameter int unsigned BUCKET_BITS = 16,
  parameter int unsigned WAYS        = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic [h3act_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [h3act_pkg::CFG_W-1:0]        cfg_data_i,
  // request channel
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire h3act_pkg::h3act_req_t              in_req_i,
  // response channel
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output h3act_pkg::h3act_rsp_t                   out_rsp_o
);
  import h3act_pkg::*;

  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RowW = WAYS * ENTRY_W;
  localparam logic [WayW-1:0] LastWay = WayW'(WAYS - 1);

  // Configuration registers
  logic [CNT_W-1:0]                limit_q;
  logic [ROW_GRPS-1:0][CFG_W-1:0]  rows_q;

  // Sequencer state
  h3act_state_e              state_q, state_d;
  h3act_req_t                req_q, req_d;
  logic [BUCKET_BITS-1:0]    bucket_q, bucket_d;
  logic [BUCKET_BITS-1:0]    sweep_q, sweep_d;
  logic                      clr_reply_q, clr_reply_d;
  logic [WayW-1:0]           way_q, way_d;
  logic                      hit_q, hit_d;
  logic [WayW-1:0]           hit_way_q, hit_way_d;
  logic                      free_q, free_d;
  logic [WayW-1:0]           free_way_q, free_way_d;
  h3act_rsp_t                res_q, res_d;
  logic [TOTAL_W-1:0]        total_q, total_d;
  logic                      out_valid_q, out_valid_d;
  h3act_rsp_t                out_q, out_d;

  // Hash unit and bucket memory hookup
  h3act_rows_t               hash_rows;
  logic                      hash_start;
  logic                      hash_done;
  logic [KEY_W-1:0]          hash_val;
  logic                      mem_we;
  logic                      mem_re;
  logic [BUCKET_BITS-1:0]    mem_waddr;
  logic [RowW-1:0]           mem_wdata;
  logic [RowW-1:0]           rd_row;
  logic [TOTAL_W-1:0]        total_inc;

  // The four 64-bit registers pack rows 0..15 in the same bit order.
  assign hash_rows = rows_q;

  h3act_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (in_req_i.key),
    .rows_i  (hash_rows),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  h3act_bucket_ram #(
    .AddrW (BUCKET_BITS),
    .DataW (RowW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (hash_val[BUCKET_BITS-1:0]),
    .rdata_o (rd_row)
  );

  // Configuration writes; out-of-range indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      rows_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COUNT_LIMIT: limit_q   <= cfg_data_i[CNT_W-1:0];
        CFG_HASH_ROWS_A: rows_q[0] <= cfg_data_i;
        CFG_HASH_ROWS_B: rows_q[1] <= cfg_data_i;
        CFG_HASH_ROWS_C: rows_q[2] <= cfg_data_i;
        CFG_HASH_ROWS_D: rows_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control registers; reset starts with a clearing walk that sends no response.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      clr_reply_q <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      way_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      clr_reply_q <= clr_reply_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      way_q       <= way_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    bucket_q   <= bucket_d;
    hit_way_q  <= hit_way_d;
    free_way_q <= free_way_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // Saturating bump of the insert total
  assign total_inc = (total_q != TOTAL_MAX) ? (total_q + 1'b1) : total_q;

  always_comb begin
    h3act_entry_t scan_ent;
    h3act_entry_t upd_ent;
    logic [WayW-1:0] upd_way;
    logic            upd_wr;

    state_d     = state_q;
    req_d       = req_q;
    bucket_d    = bucket_q;
    sweep_d     = sweep_q;
    clr_reply_d = clr_reply_q;
    way_d       = way_q;
    hit_d       = hit_q;
    hit_way_d   = hit_way_q;
    free_d      = free_q;
    free_way_d  = free_way_q;
    res_d       = res_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    hash_start  = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = bucket_q;
    mem_wdata   = rd_row;
    in_ready_o  = 1'b0;
    scan_ent    = h3act_entry_t'(rd_row[way_q*ENTRY_W +: ENTRY_W]);
    upd_ent     = h3act_entry_t'(rd_row[hit_way_q*ENTRY_W +: ENTRY_W]);
    upd_way     = hit_way_q;
    upd_wr      = 1'b0;

    // Drop the response once the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_SWEEP: begin
        // Invalidate one bucket a cycle.
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == '1) begin
          state_d     = clr_reply_q ? ST_DONE : ST_IDLE;
          clr_reply_d = 1'b0;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d = in_req_i;
          if (in_req_i.op == OP_CLEAR) begin
            total_d     = '0;
            sweep_d     = '0;
            clr_reply_d = 1'b1;
            res_d       = '0;
            state_d     = ST_SWEEP;
          end else begin
            hash_start = 1'b1;
            state_d    = ST_HASH;
          end
        end
      end

      ST_HASH: begin
        // Launch the bucket read as soon as the hash settles.
        if (hash_done) begin
          mem_re   = 1'b1;
          bucket_d = hash_val[BUCKET_BITS-1:0];
          way_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          state_d  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // One way per cycle: first matching valid way, first free way.
        if (scan_ent.valid) begin
          if (!hit_q && (scan_ent.key == req_q.key)) begin
            hit_d     = 1'b1;
            hit_way_d = way_q;
          end
        end else if (!free_q) begin
          free_d     = 1'b1;
          free_way_d = way_q;
        end
        way_d = way_q + 1'b1;
        if (way_q == LastWay) begin
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        res_d = '0;
        if (hit_q) begin
          res_d.key_found = 1'b1;
          case (req_q.op)
            OP_INSERT: begin
              if (upd_ent.count < limit_q) begin
                upd_ent.count = upd_ent.count + 1'b1;
                total_d       = total_inc;
                upd_wr        = 1'b1;
              end else begin
                res_d.blocked = 1'b1;
              end
              res_d.access_count = upd_ent.count;
            end
            OP_QUERY: begin
              res_d.access_count = upd_ent.count;
            end
            OP_REMOVE: begin
              upd_ent = '0;
              upd_wr  = 1'b1;
            end
            default: ;
          endcase
        end else if (req_q.op == OP_INSERT) begin
          if (free_q) begin
            upd_ent.valid      = 1'b1;
            upd_ent.key        = req_q.key;
            upd_ent.count      = CNT_W'(1);
            upd_way            = free_way_q;
            upd_wr             = 1'b1;
            total_d            = total_inc;
            res_d.access_count = CNT_W'(1);
          end else begin
            res_d.bucket_full = 1'b1;
          end
        end
        mem_we = upd_wr;
        mem_wdata[upd_way*ENTRY_W +: ENTRY_W] = upd_ent;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register frees up.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d             = res_q;
          out_d.total_count = total_q;
          out_d.table_empty = (total_q == '0);
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `H3ACT_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `H3ACT_ASSERT(a_way_in_range, clk_i, rst_ni, state_q == ST_SCAN |-> way_q <= LastWay)
  `H3ACT_ASSERT_NEVER(a_blocked_and_full, clk_i, rst_ni, state_q == ST_DONE && res_q.blocked && res_q.bucket_full)
  `H3ACT_ASSERT(a_empty_flag, clk_i, rst_ni, out_valid_o |-> out_rsp_o.table_empty == (out_rsp_o.total_count == '0))
  `H3ACT_ASSERT_NEVER(a_no_write_idle, clk_i, rst_ni, mem_we && state_q == ST_IDLE)

endmodule
`default_nettype wire
